### sv/lmsd_pkg.sv
package lmsd_pkg;

   // Panel geometry and bit-plane count.
   localparam int ROWS      = 32;
   localparam int COLS      = 64;
   localparam int PLANES    = 8;
   localparam int HALF_ROWS = ROWS / 2;

   // Derived widths.
   localparam int LINE_W    = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
   localparam int COL_W     = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int PLANE_W   = (PLANES > 1) ? $clog2(PLANES) : 1;
   localparam int ADDR_W    = LINE_W + COL_W;
   localparam int RAM_DEPTH = 1 << ADDR_W;
   localparam int UNIT_W    = 16;
   localparam int PULSE_W   = UNIT_W + PLANES - 1;
   localparam int ADDR_PIN_W = 4;

   // One stored pixel: red, green and blue, eight bits each.
   localparam int COLOR_W   = 8;
   localparam int PIXEL_W   = 3 * COLOR_W;
   localparam int RED_LSB   = 2 * COLOR_W;
   localparam int GREEN_LSB = COLOR_W;
   localparam int BLUE_LSB  = 0;

   localparam logic [UNIT_W-1:0] PULSE_UNIT_RESET = 16'd16;

   // Item kinds.
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   typedef struct packed {
      logic         kind;
      logic [4:0]   pixel_row;
      logic [5:0]   pixel_col;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
   } req_type;

   typedef struct packed {
      logic         red_top;
      logic         green_top;
      logic         blue_top;
      logic         red_bottom;
      logic         green_bottom;
      logic         blue_bottom;
      logic         shift_clock;
      logic         latch;
      logic         output_enable;
      logic [3:0]   line_address;
   } rsp_type;

   // Pin levels and frame store read request for one tick.
   typedef struct packed {
      logic [LINE_W-1:0]     rd_line;
      logic [COL_W-1:0]      rd_col;
      logic [PLANE_W-1:0]    plane;
      logic                  data_en;
      logic                  shift_clock;
      logic                  latch;
      logic                  output_enable;
      logic [ADDR_PIN_W-1:0] line_address;
   } scan_ctl_type;

endpackage

### sv/lmsd_ram.sv
module lmsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lmsd_frame_store.sv
module lmsd_frame_store
   import lmsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_fire,
   input  req_type            wr_item,
   input  logic               rd_en,
   input  logic [LINE_W-1:0]  rd_line,
   input  logic [COL_W-1:0]   rd_col,
   output logic [PIXEL_W-1:0] top_data,
   output logic [PIXEL_W-1:0] bot_data,
   output logic               clearing
);

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              in_panel;
   logic              is_bottom;
   logic [LINE_W-1:0] wr_line;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIXEL_W-1:0] wr_data;
   logic              top_we;
   logic              bot_we;
   logic [ADDR_W-1:0] rd_addr;

   // Clearing pass after reset: one entry of each half per cycle.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(RAM_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Split a pixel write between the top-half and bottom-half stores; while clearing, both get zeros.
   always_comb begin
      in_panel  = (32'(wr_item.pixel_row) < ROWS) && (32'(wr_item.pixel_col) < COLS);
      is_bottom = 32'(wr_item.pixel_row) >= HALF_ROWS;
      wr_line   = is_bottom ? LINE_W'(32'(wr_item.pixel_row) - HALF_ROWS)
                            : LINE_W'(wr_item.pixel_row);
      if (clearing_ff) begin
         wr_addr = clr_addr_ff;
         wr_data = '0;
         top_we  = 1'b1;
         bot_we  = 1'b1;
      end else begin
         wr_addr = {wr_line, COL_W'(wr_item.pixel_col)};
         wr_data = {wr_item.red, wr_item.green, wr_item.blue};
         top_we  = wr_fire && in_panel && !is_bottom;
         bot_we  = wr_fire && in_panel && is_bottom;
      end
   end

   assign rd_addr  = {rd_line, rd_col};
   assign clearing = clearing_ff;

   lmsd_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (RAM_DEPTH)
   ) u_top_ram (
      .clock   (clock),
      .wr_en   (top_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (top_data)
   );

   lmsd_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (RAM_DEPTH)
   ) u_bot_ram (
      .clock   (clock),
      .wr_en   (bot_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (bot_data)
   );

endmodule

### sv/lmsd_sequencer.sv
module lmsd_sequencer
   import lmsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              tick_fire,
   input  logic [UNIT_W-1:0] pulse_unit,
   output scan_ctl_type      ctl
);

   typedef enum logic [2:0] {
      PH_SHIFT_LOW,
      PH_SHIFT_HIGH,
      PH_ADDRESS,
      PH_LATCH,
      PH_ENABLE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [LINE_W-1:0]     line_ff, line_in;
   logic [PLANE_W-1:0]    plane_ff, plane_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [PULSE_W-1:0]    count_ff, count_in;
   logic [ADDR_PIN_W-1:0] shown_ff, shown_in;
   logic [PULSE_W-1:0]    pulse_len;
   logic [PULSE_W-1:0]    count_next;

   // Pin levels of the current tick and the next sequence position.
   always_comb begin
      phase_in   = phase_ff;
      line_in    = line_ff;
      plane_in   = plane_ff;
      col_in     = col_ff;
      count_in   = count_ff;
      shown_in   = shown_ff;
      pulse_len  = PULSE_W'(pulse_unit) << plane_ff;
      count_next = count_ff + 1'b1;

      ctl.rd_line       = line_ff;
      ctl.rd_col        = col_ff;
      ctl.plane         = plane_ff;
      ctl.data_en       = 1'b0;
      ctl.shift_clock   = 1'b0;
      ctl.latch         = 1'b0;
      ctl.output_enable = 1'b0;

      unique case (phase_ff)
         PH_SHIFT_LOW: begin
            ctl.data_en = 1'b1;
            phase_in    = PH_SHIFT_HIGH;
         end
         PH_SHIFT_HIGH: begin
            ctl.data_en     = 1'b1;
            ctl.shift_clock = 1'b1;
            if (col_ff == COL_W'(COLS - 1)) begin
               col_in   = '0;
               phase_in = PH_ADDRESS;
            end else begin
               col_in   = col_ff + 1'b1;
               phase_in = PH_SHIFT_LOW;
            end
         end
         PH_ADDRESS: begin
            shown_in = ADDR_PIN_W'(line_ff);
            phase_in = PH_LATCH;
         end
         PH_LATCH: begin
            ctl.latch = 1'b1;
            count_in  = '0;
            phase_in  = PH_ENABLE;
         end
         PH_ENABLE: begin
            ctl.output_enable = 1'b1;
            count_in          = count_next;
            if (count_next >= pulse_len) begin
               count_in = '0;
               phase_in = PH_SHIFT_LOW;
               if (plane_ff == PLANE_W'(PLANES - 1)) begin
                  plane_in = '0;
                  line_in  = (line_ff == LINE_W'(HALF_ROWS - 1)) ? '0 : line_ff + 1'b1;
               end else begin
                  plane_in = plane_ff + 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_SHIFT_LOW;
         end
      endcase

      // The address pins show the value taken during this tick.
      ctl.line_address = shown_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SHIFT_LOW;
         line_ff  <= '0;
         plane_ff <= '0;
         col_ff   <= '0;
         count_ff <= '0;
         shown_ff <= '0;
      end else if (tick_fire) begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         plane_ff <= plane_in;
         col_ff   <= col_in;
         count_ff <= count_in;
         shown_ff <= shown_in;
      end
   end

endmodule

### sv/led_matrix_scan_driver.sv
// Channel   Ports                                   Direction
// req       req_valid, req_stall, req_payload       in: tick or pixel write
// rsp       rsp_valid, rsp_stall, rsp_payload       out: panel pin levels
// csr       csr_write_enable, csr_write_data        in: output-enable unit
//
// Every item passes the read stage and the output register, and one item is
// taken in every cycle unless a stalled result holds the pipeline. The frame
// store read for a tick is issued at its transfer and its registered data is
// used in the read stage. After reset the frame store is cleared, one entry of
// each panel half per cycle, and no item is taken meanwhile.
// A stalled result holds the pipeline; items keep flowing while stages are free.
module led_matrix_scan_driver
   import lmsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [UNIT_W-1:0]  pulse_unit_ff;
   logic               clearing;
   logic               req_fire;
   logic               tick_fire;
   logic               write_fire;
   logic               out_free;
   scan_ctl_type       ctl;
   logic [PIXEL_W-1:0] top_data;
   logic [PIXEL_W-1:0] bot_data;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_kind_ff;
   scan_ctl_type       s1_ctl_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   rsp_type            held_ff;
   rsp_type            tick_pins;
   logic [COLOR_W-1:0] top_r, top_g, top_b, bot_r, bot_g, bot_b;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_unit_ff <= PULSE_UNIT_RESET;
      end else if (csr_write_enable) begin
         pulse_unit_ff <= csr_write_data;
      end
   end

   // Input transfer and stage advance.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = clearing || (s1_valid_ff && !out_free);
   assign req_fire   = req_valid && !req_stall;
   assign tick_fire  = req_fire && (req_payload.kind == KIND_TICK);
   assign write_fire = req_fire && (req_payload.kind == KIND_WRITE);

   lmsd_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .tick_fire  (tick_fire),
      .pulse_unit (pulse_unit_ff),
      .ctl        (ctl)
   );

   lmsd_frame_store u_frame_store (
      .clock    (clock),
      .reset    (reset),
      .wr_fire  (write_fire),
      .wr_item  (req_payload),
      .rd_en    (tick_fire),
      .rd_line  (ctl.rd_line),
      .rd_col   (ctl.rd_col),
      .top_data (top_data),
      .bot_data (bot_data),
      .clearing (clearing)
   );

   // Read stage: holds the tick's control while the pixels are read.
   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_kind_ff <= req_payload.kind;
         s1_ctl_ff  <= ctl;
      end
   end

   // Pin levels of a tick: plane bits of the top and bottom pixels.
   always_comb begin
      top_r = top_data[RED_LSB +: COLOR_W] >> s1_ctl_ff.plane;
      top_g = top_data[GREEN_LSB +: COLOR_W] >> s1_ctl_ff.plane;
      top_b = top_data[BLUE_LSB +: COLOR_W] >> s1_ctl_ff.plane;
      bot_r = bot_data[RED_LSB +: COLOR_W] >> s1_ctl_ff.plane;
      bot_g = bot_data[GREEN_LSB +: COLOR_W] >> s1_ctl_ff.plane;
      bot_b = bot_data[BLUE_LSB +: COLOR_W] >> s1_ctl_ff.plane;

      tick_pins.red_top       = s1_ctl_ff.data_en && top_r[0];
      tick_pins.green_top     = s1_ctl_ff.data_en && top_g[0];
      tick_pins.blue_top      = s1_ctl_ff.data_en && top_b[0];
      tick_pins.red_bottom    = s1_ctl_ff.data_en && bot_r[0];
      tick_pins.green_bottom  = s1_ctl_ff.data_en && bot_g[0];
      tick_pins.blue_bottom   = s1_ctl_ff.data_en && bot_b[0];
      tick_pins.shift_clock   = s1_ctl_ff.shift_clock;
      tick_pins.latch         = s1_ctl_ff.latch;
      tick_pins.output_enable = s1_ctl_ff.output_enable;
      tick_pins.line_address  = s1_ctl_ff.line_address;
   end

   // Output register: a pixel write repeats the pins of the last tick.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         rsp_in       = (s1_kind_ff == KIND_TICK) ? tick_pins : held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (out_free && s1_valid_ff && (s1_kind_ff == KIND_TICK)) begin
            held_ff <= tick_pins;
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sim/led_matrix_scan_driver_tb.sv
`timescale 1ns / 100ps

module led_matrix_scan_driver_tb;
   import lmsd_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int DIR_ROWS      = 20;
   localparam int RANDOM_PHASES = 5;
   localparam int REPORT_MAX    = 10;

   // Output-enable unit and item count for each random phase; the extremes come first.
   localparam logic [UNIT_W-1:0] PHASE_UNIT [RANDOM_PHASES] =
      '{16'hFFFF, 16'd0, 16'd1, 16'd7, 16'd0};
   localparam int PHASE_ITEMS [RANDOM_PHASES] = '{150, 250, 200, 150, 200};

   // Steps of the scan sequence.
   typedef enum logic [2:0] {
      SEQ_SHIFT_LOW,
      SEQ_SHIFT_HIGH,
      SEQ_ADDRESS,
      SEQ_LATCH,
      SEQ_ENABLE
   } seq_step_type;

   // One row of the directed table; want is used only when typed is set.
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   localparam req_type TICK_ITEM  = '0;
   localparam req_type NOISY_TICK = '{kind: KIND_TICK, pixel_row: 5'd31, pixel_col: 6'd63,
                                      red: 8'hFF, green: 8'hFF, blue: 8'hFF};
   localparam rsp_type PINS_DARK  = '0;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   req_type     req_payload      = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data   = '0;

   // Predicted panel state.
   logic [PIXEL_W-1:0]    frame_px [ROWS*COLS];
   logic [UNIT_W-1:0]     pulse_unit_q = PULSE_UNIT_RESET;
   logic [LINE_W-1:0]     line_q       = '0;
   logic [PLANE_W-1:0]    plane_q      = '0;
   logic [6:0]            col_q        = '0;
   seq_step_type          step_q       = SEQ_SHIFT_LOW;
   logic [PULSE_W-1:0]    pulse_cnt_q  = '0;
   logic [ADDR_PIN_W-1:0] addr_q       = '0;
   rsp_type               held_pins    = '0;

   rsp_type pending_pins [$];

   int  ticks_sent     = 0;
   int  writes_sent    = 0;
   int  unit_settings  = 0;
   int  results_seen   = 0;
   int  pin_mismatches = 0;
   int  quiet_cycles   = 0;
   int  stall_left     = 0;
   bit  req_idle_ok    = 1'b1;
   bit  rsp_idle_ok    = 1'b1;

   led_matrix_scan_driver i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic req_type pixel_write(input logic [4:0] row, input logic [5:0] col,
                                           input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      req_type item;
      item = '{kind: KIND_WRITE, pixel_row: row, pixel_col: col, red: r, green: g, blue: b};
      return item;
   endfunction

   // Pin levels the panel shows after one item; pixel writes repeat the last tick's pins.
   function automatic rsp_type next_panel_pins(input req_type item);
      rsp_type            pins;
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] bot;
      logic [PULSE_W-1:0] span;
      pins = '0;
      if (item.kind == KIND_WRITE) begin
         if (int'(item.pixel_row) < ROWS && int'(item.pixel_col) < COLS) begin
            frame_px[int'(item.pixel_row) * COLS + int'(item.pixel_col)] =
               {item.red, item.green, item.blue};
         end
         return held_pins;
      end
      top = frame_px[int'(line_q) * COLS + int'(col_q) % COLS];
      bot = frame_px[(int'(line_q) + HALF_ROWS) * COLS + int'(col_q) % COLS];
      case (step_q)
         SEQ_SHIFT_LOW, SEQ_SHIFT_HIGH: begin
            pins.red_top      = top[RED_LSB + plane_q];
            pins.green_top    = top[GREEN_LSB + plane_q];
            pins.blue_top     = top[BLUE_LSB + plane_q];
            pins.red_bottom   = bot[RED_LSB + plane_q];
            pins.green_bottom = bot[GREEN_LSB + plane_q];
            pins.blue_bottom  = bot[BLUE_LSB + plane_q];
            if (step_q == SEQ_SHIFT_LOW) begin
               step_q = SEQ_SHIFT_HIGH;
            end else begin
               pins.shift_clock = 1'b1;
               if (int'(col_q) + 1 >= COLS) begin
                  col_q  = '0;
                  step_q = SEQ_ADDRESS;
               end else begin
                  col_q++;
                  step_q = SEQ_SHIFT_LOW;
               end
            end
         end
         SEQ_ADDRESS: begin
            addr_q = ADDR_PIN_W'(line_q);
            step_q = SEQ_LATCH;
         end
         SEQ_LATCH: begin
            pins.latch  = 1'b1;
            pulse_cnt_q = '0;
            step_q      = SEQ_ENABLE;
         end
         default: begin
            // A zero unit still gives one enable tick, since the count is checked after it.
            span = PULSE_W'(pulse_unit_q) << plane_q;
            pins.output_enable = 1'b1;
            pulse_cnt_q++;
            if (pulse_cnt_q >= span) begin
               pulse_cnt_q = '0;
               step_q      = SEQ_SHIFT_LOW;
               if (int'(plane_q) + 1 >= PLANES) begin
                  plane_q = '0;
                  line_q  = (int'(line_q) + 1 >= HALF_ROWS) ? '0 : line_q + 1'b1;
               end else begin
                  plane_q++;
               end
            end
         end
      endcase
      pins.line_address = addr_q;
      held_pins = pins;
      return pins;
   endfunction

   function automatic string pins_text(input rsp_type p);
      return $sformatf("top=%b%b%b bottom=%b%b%b clk=%b latch=%b oe=%b addr=%0d",
                       p.red_top, p.green_top, p.blue_top, p.red_bottom, p.green_bottom,
                       p.blue_bottom, p.shift_clock, p.latch, p.output_enable, p.line_address);
   endfunction

   // Offers one item, waits for its transfer and queues the pins it should produce.
   task automatic send_item(input req_type item, input logic typed, input rsp_type want);
      rsp_type pins;
      if (req_idle_ok && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      pins = next_panel_pins(item);
      pending_pins.push_back(typed ? want : pins);
      if (item.kind == KIND_WRITE) writes_sent++;
      else ticks_sent++;
   endtask

   // Writes the output-enable unit once every queued result has come back.
   task automatic set_pulse_unit(input logic [UNIT_W-1:0] unit);
      while (pending_pins.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= unit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pulse_unit_q = unit;
      unit_settings++;
   endtask

   // Stimulus: directed table, then random phases under different output-enable units.
   initial begin
      dir_row_type dir_table [DIR_ROWS];
      req_type     item;
      int          p;
      int          n;
      foreach (frame_px[i]) frame_px[i] = '0;
      dir_table = '{
         '{pixel_write(5'd0,  6'd0,  8'hFF, 8'hFF, 8'hFF), 1'b1, PINS_DARK},
         '{pixel_write(5'd16, 6'd0,  8'h00, 8'hFF, 8'h00), 1'b1, PINS_DARK},
         '{pixel_write(5'd31, 6'd63, 8'hFF, 8'h00, 8'hFF), 1'b1, PINS_DARK},
         '{pixel_write(5'd15, 6'd63, 8'h80, 8'h01, 8'h7F), 1'b1, PINS_DARK},
         '{TICK_ITEM, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0}},
         '{TICK_ITEM, 1'b0, PINS_DARK},
         '{pixel_write(5'd0,  6'd1,  8'h01, 8'h02, 8'h04), 1'b0, PINS_DARK},
         '{pixel_write(5'd16, 6'd1,  8'h80, 8'h40, 8'h20), 1'b0, PINS_DARK},
         '{TICK_ITEM, 1'b0, PINS_DARK},
         '{NOISY_TICK, 1'b0, PINS_DARK},
         '{pixel_write(5'd0,  6'd0,  8'h00, 8'h00, 8'h00), 1'b0, PINS_DARK},
         '{pixel_write(5'd0,  6'd2,  8'hAA, 8'h55, 8'hF0), 1'b0, PINS_DARK},
         '{TICK_ITEM, 1'b0, PINS_DARK},
         '{TICK_ITEM, 1'b0, PINS_DARK},
         '{TICK_ITEM, 1'b0, PINS_DARK},
         '{TICK_ITEM, 1'b0, PINS_DARK},
         '{pixel_write(5'd16, 6'd3,  8'h7F, 8'h80, 8'hFE), 1'b0, PINS_DARK},
         '{TICK_ITEM, 1'b0, PINS_DARK},
         '{TICK_ITEM, 1'b0, PINS_DARK},
         '{TICK_ITEM, 1'b0, PINS_DARK}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
      req_valid <= 1'b0;

      for (p = 0; p < RANDOM_PHASES; p++) begin
         set_pulse_unit(PHASE_UNIT[p]);
         if (p == RANDOM_PHASES - 1) begin
            req_idle_ok = 1'b0;
            rsp_idle_ok = 1'b0;
         end
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            // Mostly ticks; writes favor the two rows being scanned so that lit bits shift out.
            item.kind      = ($urandom_range(0, 99) < 85) ? KIND_TICK : KIND_WRITE;
            item.pixel_row = 5'($urandom_range(0, ROWS - 1));
            item.pixel_col = 6'($urandom_range(0, COLS - 1));
            item.red       = 8'($urandom);
            item.green     = 8'($urandom);
            item.blue      = 8'($urandom);
            if (item.kind == KIND_WRITE && $urandom_range(0, 1) == 1) begin
               item.pixel_row = 5'(line_q) + ($urandom_range(0, 1) == 1 ? 5'(HALF_ROWS) : 5'd0);
            end
            send_item(item, 1'b0, PINS_DARK);
         end
         req_valid <= 1'b0;
      end

      // Drain, then let the pipeline show any stray transfer.
      while (pending_pins.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("Checked %0d results from %0d ticks and %0d pixel writes under %0d enable units.",
               results_seen, ticks_sent, writes_sent, unit_settings);
      $display("The scan sequence ended at line %0d, bit plane %0d.", line_q, plane_q);
      if (pin_mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d result mismatches.", pin_mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_idle_ok && (stall_left > 0 || $urandom_range(0, 7) == 0)) begin
         if (stall_left == 0) stall_left = $urandom_range(1, 3);
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transfer with the oldest queued prediction.
   always @(posedge clock) begin
      rsp_type want;
      string   bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_pins.size() == 0) begin
            pin_mismatches++;
            if (pin_mismatches <= REPORT_MAX)
               $display("Result %0d arrived with nothing expected: %s",
                        results_seen, pins_text(rsp_payload));
         end else begin
            want = pending_pins.pop_front();
            bad  = "";
            if (rsp_payload.red_top       !== want.red_top)       bad = {bad, " red_top"};
            if (rsp_payload.green_top     !== want.green_top)     bad = {bad, " green_top"};
            if (rsp_payload.blue_top      !== want.blue_top)      bad = {bad, " blue_top"};
            if (rsp_payload.red_bottom    !== want.red_bottom)    bad = {bad, " red_bottom"};
            if (rsp_payload.green_bottom  !== want.green_bottom)  bad = {bad, " green_bottom"};
            if (rsp_payload.blue_bottom   !== want.blue_bottom)   bad = {bad, " blue_bottom"};
            if (rsp_payload.shift_clock   !== want.shift_clock)   bad = {bad, " shift_clock"};
            if (rsp_payload.latch         !== want.latch)         bad = {bad, " latch"};
            if (rsp_payload.output_enable !== want.output_enable) bad = {bad, " output_enable"};
            if (rsp_payload.line_address  !== want.line_address)  bad = {bad, " line_address"};
            if (bad != "") begin
               pin_mismatches++;
               if (pin_mismatches <= REPORT_MAX)
                  $display("Result %0d wrong in%s: expected %s, got %s",
                           results_seen, bad, pins_text(want), pins_text(rsp_payload));
            end
         end
      end
   end

   // Watchdog on cycles without any transfer; covers the frame store clear after reset.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
         $display("No transfer for %0d cycles, %0d results still expected.",
                  IDLE_LIMIT, pending_pins.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
